// ===== rtl/source_char_tokenizer_assert.svh =====
// Assertion macros shared by the tokenizer RTL.
// Each macro expects clk and rst_n to be visible at the point of use.
`ifndef SOURCE_CHAR_TOKENIZER_ASSERT_SVH
`define SOURCE_CHAR_TOKENIZER_ASSERT_SVH

`ifndef SYNTH

// Check that expr holds at every clock edge outside reset.
`define SCT_ASSERT_ALWAYS(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("tokenizer assertion failed");

// Check that cons holds at every edge where ante holds.
`define SCT_ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tokenizer assertion failed");

`else

`define SCT_ASSERT_ALWAYS(label, expr)
`define SCT_ASSERT_IMPLIES(label, ante, cons)

`endif

`endif

// ===== rtl/sct_pkg.sv =====
package sct_pkg;

    localparam int KIND_W       = 5;
    localparam int KEYWORDS     = 6;
    localparam int KW_MAX_CHARS = 6;
    localparam int QUEUE_DEPTH  = 4;

    // Token slots carried by one queue entry, in emission order
    localparam int SLOTS       = 3;
    localparam int SLOT_FIRST  = 0;
    localparam int SLOT_SECOND = 1;
    localparam int SLOT_END    = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_INT    = 5'd0,
        KIND_FLOAT  = 5'd1,
        KIND_BOOL   = 5'd2,
        KIND_STRING = 5'd3,
        KIND_COUT   = 5'd4,
        KIND_CIN    = 5'd5,
        KIND_IDENT  = 5'd6,
        KIND_NUMBER = 5'd7,
        KIND_PLUS   = 5'd8,
        KIND_MINUS  = 5'd9,
        KIND_MUL    = 5'd10,
        KIND_DIV    = 5'd11,
        KIND_ASSIGN = 5'd12,
        KIND_SEMI   = 5'd13,
        KIND_LSHIFT = 5'd14,
        KIND_RSHIFT = 5'd15,
        KIND_END    = 5'd16
    } token_kind_t;

    typedef enum logic [4:0] {
        MODE_IDLE   = 5'b00001,
        MODE_IDENT  = 5'b00010,
        MODE_NUMBER = 5'b00100,
        MODE_LT     = 5'b01000,
        MODE_GT     = 5'b10000
    } scan_mode_t;

    // Keyword spellings, first character in the lowest byte
    localparam logic [8*KW_MAX_CHARS-1:0] KW_TEXT [KEYWORDS] = '{
        48'h000000746E69,   // int
        48'h0074616F6C66,   // float
        48'h00006C6F6F62,   // bool
        48'h676E69727473,   // string
        48'h000074756F63,   // cout
        48'h0000006E6963    // cin
    };

    localparam logic [2:0] KW_LEN [KEYWORDS] = '{
        3'd3, 3'd5, 3'd4, 3'd6, 3'd4, 3'd3
    };

    // Map an identifier to its keyword kind; len is zero for lengths above six
    function automatic token_kind_t keyword_kind(
        input logic [8*KW_MAX_CHARS-1:0] pfx,
        input logic [2:0]                len
    );
        token_kind_t kind;
        logic        hit;
        kind = KIND_IDENT;
        for (int k = KEYWORDS - 1; k >= 0; k--)
        begin
            hit = (len == KW_LEN[k]);
            for (int i = 0; i < KW_MAX_CHARS; i++)
            begin
                if ((3'(i) < KW_LEN[k]) && (pfx[8*i +: 8] != KW_TEXT[k][8*i +: 8]))
                begin
                    hit = 1'b0;
                end
            end
            if (hit)
            begin
                kind = token_kind_t'(KIND_W'(k));
            end
        end
        return kind;
    endfunction

endpackage

// ===== rtl/sct_queue.sv =====
`include "source_char_tokenizer_assert.svh"

module sct_queue
    import sct_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] head,
    output logic             empty
);

    // DEPTH is a power of two so the pointers wrap on their own
    localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]   entry_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;

    assign full  = (count_reg == COUNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + COUNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - COUNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store pushed entries
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    `SCT_ASSERT_IMPLIES(no_push_when_full, push, !full)
    `SCT_ASSERT_IMPLIES(no_pop_when_empty, pop, !empty)
    `SCT_ASSERT_ALWAYS(count_in_range, count_reg <= COUNT_W'(DEPTH))

endmodule

// ===== rtl/sct_front.sv =====
module sct_front
    import sct_pkg::*;
#(
    parameter int ADDR_BITS    = 24,
    parameter int LENGTH_BITS  = 16,
    parameter int PREFIX_CHARS = 6,
    parameter int ENTRY_W      = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [7:0]         s_tdata,    // [7:0] ch
    input  logic               s_tlast,    // end_of_source
    input  logic [0:0]         s_tuser,    // [0] char_valid
    input  logic               q_full,
    output logic               q_push,
    output logic [ENTRY_W-1:0] q_data
);

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [ADDR_BITS-1:0]   start;
        logic [LENGTH_BITS-1:0] length;
    } token_t;

    typedef struct packed {
        logic [SLOTS-1:0]     mask;
        token_t               first;
        token_t               second;
        logic [ADDR_BITS-1:0] end_start;
    } entry_t;

    localparam logic [LENGTH_BITS-1:0] LEN_MAX = {LENGTH_BITS{1'b1}};

    scan_mode_t             mode_reg;
    scan_mode_t             mode_next;
    scan_mode_t             mode_mid;
    logic [ADDR_BITS-1:0]   start_reg;
    logic [ADDR_BITS-1:0]   start_next;
    logic [ADDR_BITS-1:0]   start_mid;
    logic [LENGTH_BITS-1:0] len_reg;
    logic [LENGTH_BITS-1:0] len_next;
    logic [LENGTH_BITS-1:0] len_mid;
    logic [LENGTH_BITS-1:0] len_inc;
    logic [ADDR_BITS-1:0]   pos_reg;
    logic [ADDR_BITS-1:0]   pos_next;
    logic [ADDR_BITS-1:0]   pos_mid;
    logic [7:0]             prefix_reg [PREFIX_CHARS];
    logic [7:0]             prefix_mid [PREFIX_CHARS];

    logic [8*KW_MAX_CHARS-1:0] pfx_reg_flat;
    logic [8*KW_MAX_CHARS-1:0] pfx_mid_flat;
    logic [7:0]                ch;
    logic                      char_valid;
    logic                      accept;
    logic                      rescan;
    entry_t                    entry;

    function automatic logic is_alpha(input logic [7:0] c);
        return c inside {["a":"z"], ["A":"Z"]};
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c inside {["0":"9"]};
    endfunction

    // Length code for the keyword table: zero when too long to be a keyword
    function automatic logic [2:0] short_len(input logic [LENGTH_BITS-1:0] len);
        return (len <= LENGTH_BITS'(KW_MAX_CHARS)) ? len[2:0] : 3'd0;
    endfunction

    assign ch         = s_tdata;
    assign char_valid = s_tuser[0];
    assign s_tready   = !q_full;
    assign accept     = s_tvalid && s_tready;
    assign len_inc    = (len_reg == LEN_MAX) ? len_reg : len_reg + LENGTH_BITS'(1);

    // Flatten the keyword-sized prefix for the table compare
    always_comb
    begin
        for (int i = 0; i < KW_MAX_CHARS; i++)
        begin
            pfx_reg_flat[8*i +: 8] = prefix_reg[i];
            pfx_mid_flat[8*i +: 8] = prefix_mid[i];
        end
    end

    // Scan one transaction: byte first, then the end-of-source flush
    always_comb
    begin
        mode_mid   = mode_reg;
        start_mid  = start_reg;
        len_mid    = len_reg;
        pos_mid    = pos_reg;
        prefix_mid = prefix_reg;
        rescan     = 1'b0;
        entry      = '0;

        if (char_valid)
        begin
            pos_mid = pos_reg + ADDR_BITS'(1);
            case (mode_reg)
                MODE_IDENT, MODE_NUMBER:
                begin
                    if (is_digit(ch) || (mode_reg == MODE_IDENT && is_alpha(ch)))
                    begin
                        // Extend the lexeme, keeping the leading characters
                        for (int i = 0; i < PREFIX_CHARS; i++)
                        begin
                            if (len_reg == LENGTH_BITS'(i))
                            begin
                                prefix_mid[i] = ch;
                            end
                        end
                        len_mid = len_inc;
                    end
                    else
                    begin
                        entry.mask[SLOT_FIRST] = 1'b1;
                        entry.first.kind = (mode_reg == MODE_IDENT)
                            ? keyword_kind(pfx_reg_flat, short_len(len_reg))
                            : KIND_NUMBER;
                        entry.first.start  = start_reg;
                        entry.first.length = len_reg;
                        rescan = 1'b1;
                    end
                end
                MODE_LT, MODE_GT:
                begin
                    mode_mid = MODE_IDLE;
                    if (ch == ((mode_reg == MODE_LT) ? "<" : ">"))
                    begin
                        entry.mask[SLOT_SECOND] = 1'b1;
                        entry.second.kind   = (mode_reg == MODE_LT) ? KIND_LSHIFT
                                                                    : KIND_RSHIFT;
                        entry.second.start  = start_reg;
                        entry.second.length = LENGTH_BITS'(2);
                    end
                    else
                    begin
                        rescan = 1'b1;
                    end
                end
                default:
                begin
                    rescan = 1'b1;
                end
            endcase

            // Scan the byte as the start of a new item
            if (rescan)
            begin
                mode_mid = MODE_IDLE;
                if (is_alpha(ch) || is_digit(ch) || ch == "<" || ch == ">")
                begin
                    start_mid = pos_reg;
                    len_mid   = LENGTH_BITS'(1);
                    if (is_alpha(ch))
                    begin
                        mode_mid      = MODE_IDENT;
                        prefix_mid[0] = ch;
                    end
                    else if (is_digit(ch))
                    begin
                        mode_mid = MODE_NUMBER;
                    end
                    else if (ch == "<")
                    begin
                        mode_mid = MODE_LT;
                    end
                    else
                    begin
                        mode_mid = MODE_GT;
                    end
                end
                else
                begin
                    entry.second.start  = pos_reg;
                    entry.second.length = LENGTH_BITS'(1);
                    entry.mask[SLOT_SECOND] = 1'b1;
                    case (ch)
                        "+":     entry.second.kind = KIND_PLUS;
                        "-":     entry.second.kind = KIND_MINUS;
                        "*":     entry.second.kind = KIND_MUL;
                        "/":     entry.second.kind = KIND_DIV;
                        "=":     entry.second.kind = KIND_ASSIGN;
                        ";":     entry.second.kind = KIND_SEMI;
                        default: entry.mask[SLOT_SECOND] = 1'b0;
                    endcase
                end
            end
        end

        // Flush the pending lexeme and close the source
        if (s_tlast)
        begin
            if (mode_mid == MODE_IDENT || mode_mid == MODE_NUMBER)
            begin
                entry.mask[SLOT_SECOND] = 1'b1;
                entry.second.kind = (mode_mid == MODE_IDENT)
                    ? keyword_kind(pfx_mid_flat, short_len(len_mid))
                    : KIND_NUMBER;
                entry.second.start  = start_mid;
                entry.second.length = len_mid;
            end
            entry.mask[SLOT_END] = 1'b1;
            entry.end_start      = pos_mid;
        end
    end

    // Return to the reset state after the end of a source
    always_comb
    begin
        if (s_tlast)
        begin
            mode_next  = MODE_IDLE;
            start_next = '0;
            len_next   = '0;
            pos_next   = '0;
        end
        else
        begin
            mode_next  = mode_mid;
            start_next = start_mid;
            len_next   = len_mid;
            pos_next   = pos_mid;
        end
    end

    assign q_push = accept && (entry.mask != '0);
    assign q_data = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            start_reg <= '0;
            len_reg   <= '0;
            pos_reg   <= '0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            pos_reg   <= pos_next;
        end
    end

    // Hold the identifier prefix
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            prefix_reg <= prefix_mid;
        end
    end

endmodule

// ===== rtl/sct_back.sv =====
`include "source_char_tokenizer_assert.svh"

module sct_back
    import sct_pkg::*;
#(
    parameter int ADDR_BITS   = 24,
    parameter int LENGTH_BITS = 16,
    parameter int ENTRY_W     = 8,
    parameter int DATA_W      = 40
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               q_empty,
    input  logic [ENTRY_W-1:0] q_head,
    output logic               q_pop,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [DATA_W-1:0]  m_tdata,   // token_start in the low bits, then token_length
    output logic [KIND_W-1:0]  m_tuser,   // [4:0] token_kind
    output logic               m_tlast    // last_token
);

    typedef struct packed {
        logic [KIND_W-1:0]      kind;
        logic [ADDR_BITS-1:0]   start;
        logic [LENGTH_BITS-1:0] length;
    } token_t;

    typedef struct packed {
        logic [SLOTS-1:0]     mask;
        token_t               first;
        token_t               second;
        logic [ADDR_BITS-1:0] end_start;
    } entry_t;

    entry_t           head;
    logic [SLOTS-1:0] done_reg;
    logic [SLOTS-1:0] done_next;
    logic [SLOTS-1:0] pending;
    logic [SLOTS-1:0] sel;
    logic [SLOTS-1:0] rest;
    logic             load;
    token_t           pick;
    logic             valid_reg;
    token_t           tok_reg;
    logic             last_reg;

    assign head    = entry_t'(q_head);
    assign pending = head.mask & ~done_reg;
    assign sel     = pending & (~pending + SLOTS'(1));
    assign rest    = pending & ~sel;
    assign load    = !q_empty && (!valid_reg || m_tready);
    assign q_pop   = load && (rest == '0);

    // Select the earliest token still owed by the head entry
    always_comb
    begin
        if (sel[SLOT_FIRST])
        begin
            pick = head.first;
        end
        else if (sel[SLOT_SECOND])
        begin
            pick = head.second;
        end
        else
        begin
            pick.kind   = KIND_END;
            pick.start  = head.end_start;
            pick.length = '0;
        end
    end

    always_comb
    begin
        done_next = done_reg;
        if (load)
        begin
            done_next = (rest == '0) ? '0 : (done_reg | sel);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            done_reg  <= '0;
        end
        else
        begin
            done_reg <= done_next;
            if (load)
            begin
                valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Load the output register
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            tok_reg  <= pick;
            last_reg <= (rest == '0);
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = DATA_W'({tok_reg.length, tok_reg.start});
    assign m_tuser  = tok_reg.kind;
    assign m_tlast  = last_reg;

    `SCT_ASSERT_IMPLIES(done_within_mask, !q_empty, (done_reg & ~head.mask) == '0)
    `SCT_ASSERT_IMPLIES(head_has_token, !q_empty, head.mask != '0)
    `SCT_ASSERT_IMPLIES(done_clear_when_empty, q_empty, done_reg == '0)

endmodule

// ===== rtl/source_char_tokenizer.sv =====
// Source tokenizer: takes one source byte per transaction (tuser marks a real
// byte, tlast ends the source) and returns tokens, one token per output
// transaction with the kind in tuser, start position and length in tdata, and
// tlast on the last token that a byte causes. A new byte is taken every cycle
// while the four-entry queue between the scanner and the token serializer has
// room; one byte can cause up to three tokens, and the output register sends
// one token per cycle while m_tready is high, so the sustained rate is one byte
// per cycle as long as bytes average at most one token each. A token is held in
// a queue entry and then in the output register after its byte is accepted.
// Position and length counters restart at zero after end of source.
module source_char_tokenizer
    import sct_pkg::*;
#(
    parameter int ADDR_BITS    = 24,
    parameter int LENGTH_BITS  = 16,
    parameter int PREFIX_CHARS = 6
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,    // [7:0] ch
    input  logic              s_tlast,    // end_of_source
    input  logic [0:0]        s_tuser,    // [0] char_valid
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [((ADDR_BITS + LENGTH_BITS + 7) / 8) * 8 - 1:0] m_tdata,
                                          // token_start, token_length
    output logic [KIND_W-1:0] m_tuser,    // [4:0] token_kind
    output logic              m_tlast     // last_token
);

    localparam int TOKEN_W = KIND_W + ADDR_BITS + LENGTH_BITS;
    localparam int ENTRY_W = SLOTS + 2 * TOKEN_W + ADDR_BITS;
    localparam int DATA_W  = ((ADDR_BITS + LENGTH_BITS + 7) / 8) * 8;

    logic               q_full;
    logic               q_push;
    logic [ENTRY_W-1:0] q_data;
    logic               q_pop;
    logic [ENTRY_W-1:0] q_head;
    logic               q_empty;

    sct_front #(
        .ADDR_BITS    (ADDR_BITS),
        .LENGTH_BITS  (LENGTH_BITS),
        .PREFIX_CHARS (PREFIX_CHARS),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_data)
    );

    sct_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_data),
        .full      (q_full),
        .pop       (q_pop),
        .head      (q_head),
        .empty     (q_empty)
    );

    sct_back #(
        .ADDR_BITS   (ADDR_BITS),
        .LENGTH_BITS (LENGTH_BITS),
        .ENTRY_W     (ENTRY_W),
        .DATA_W      (DATA_W)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_head   (q_head),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== dv/tb_source_char_tokenizer.sv =====
`timescale 1ns / 1ps

module tb_source_char_tokenizer
    import sct_pkg::*;
();

    localparam int TDATA_W     = ((24 + 16 + 7) / 8) * 8;
    localparam int CYCLE_LIMIT = 1000000;

    // Predicts the token stream and checks each token leaving the block
    class token_scoreboard;
        typedef struct {
            token_kind_t kind;
            logic [23:0] start;
            logic [15:0] length;
            logic        last;
        } token_t;

        static string keyword_text[6] = '{"int", "float", "bool", "string", "cout", "cin"};

        scan_mode_t  mode;
        logic [7:0]  prefix [6];
        logic [15:0] lex_len;
        logic [23:0] lex_start;
        logic [23:0] byte_pos;
        int          errors;
        int          step_base;
        token_t      expected_tokens[$];

        function new();
            clear_state();
            errors = 0;
        endfunction

        function void clear_state();
            mode = MODE_IDLE;
            foreach (prefix[i])
                prefix[i] = 8'h00;
            lex_len   = '0;
            lex_start = '0;
            byte_pos  = '0;
        endfunction

        function int pending();
            return expected_tokens.size();
        endfunction

        function bit is_alpha(logic [7:0] c);
            return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
        endfunction

        function bit is_digit(logic [7:0] c);
            return c >= "0" && c <= "9";
        endfunction

        function bit is_space(logic [7:0] c);
            return c == " " || (c >= 8'd9 && c <= 8'd13);
        endfunction

        // Queue a token; one byte never causes more than three
        function void add_token(token_kind_t kind, logic [23:0] start, logic [15:0] length);
            token_t t;
            if (expected_tokens.size() - step_base >= 3)
                return;
            t.kind   = kind;
            t.start  = start;
            t.length = length;
            t.last   = 1'b0;
            expected_tokens = {expected_tokens, t};
        endfunction

        // Keyword only when the whole lexeme spells it
        function token_kind_t ident_kind();
            token_kind_t kind;
            logic        hit;
            kind = KIND_IDENT;
            for (int k = 0; k < 6; k++)
            begin
                hit = (32'(lex_len) == keyword_text[k].len());
                for (int i = 0; i < keyword_text[k].len(); i++)
                    if (prefix[i] != keyword_text[k][i])
                        hit = 1'b0;
                if (hit)
                    kind = token_kind_t'(5'(k));
            end
            return kind;
        endfunction

        function void flush_lexeme();
            if (mode == MODE_IDENT)
                add_token(ident_kind(), lex_start, lex_len);
            else if (mode == MODE_NUMBER)
                add_token(KIND_NUMBER, lex_start, lex_len);
            mode = MODE_IDLE;
        endfunction

        function void open_lexeme(scan_mode_t m);
            mode      = m;
            lex_start = byte_pos;
            lex_len   = 16'd1;
            foreach (prefix[i])
                prefix[i] = 8'h00;
        endfunction

        // Scan a byte with no lexeme in progress
        function void scan_fresh(logic [7:0] c);
            if (is_space(c))
                return;
            if (is_alpha(c))
            begin
                open_lexeme(MODE_IDENT);
                prefix[0] = c;
            end
            else if (is_digit(c))
                open_lexeme(MODE_NUMBER);
            else
            begin
                case (c)
                    "+": add_token(KIND_PLUS, byte_pos, 16'd1);
                    "-": add_token(KIND_MINUS, byte_pos, 16'd1);
                    "*": add_token(KIND_MUL, byte_pos, 16'd1);
                    "/": add_token(KIND_DIV, byte_pos, 16'd1);
                    "=": add_token(KIND_ASSIGN, byte_pos, 16'd1);
                    ";": add_token(KIND_SEMI, byte_pos, 16'd1);
                    "<": open_lexeme(MODE_LT);
                    ">": open_lexeme(MODE_GT);
                    default: ;
                endcase
            end
        endfunction

        function void extend_lexeme(logic [7:0] c);
            if (lex_len < 16'd6)
                prefix[lex_len] = c;
            if (lex_len != 16'hFFFF)
                lex_len++;
        endfunction

        // Advance the model by one accepted input transaction
        function void take_byte(logic [7:0] c, logic char_valid, logic eos);
            logic [7:0]  want;
            token_kind_t pair_kind;
            step_base = expected_tokens.size();
            if (char_valid)
            begin
                case (mode)
                    MODE_IDENT:
                    begin
                        if (is_alpha(c) || is_digit(c))
                            extend_lexeme(c);
                        else
                        begin
                            flush_lexeme();
                            scan_fresh(c);
                        end
                    end
                    MODE_NUMBER:
                    begin
                        if (is_digit(c))
                            extend_lexeme(c);
                        else
                        begin
                            flush_lexeme();
                            scan_fresh(c);
                        end
                    end
                    MODE_LT, MODE_GT:
                    begin
                        want      = (mode == MODE_LT) ? 8'h3C : 8'h3E;
                        pair_kind = (mode == MODE_LT) ? KIND_LSHIFT : KIND_RSHIFT;
                        mode      = MODE_IDLE;
                        if (c == want)
                            add_token(pair_kind, lex_start, 16'd2);
                        else
                            scan_fresh(c);
                    end
                    default:
                    begin
                        mode = MODE_IDLE;
                        scan_fresh(c);
                    end
                endcase
                byte_pos = byte_pos + 24'd1;
            end
            if (eos)
            begin
                flush_lexeme();
                add_token(KIND_END, byte_pos, 16'd0);
                clear_state();
            end
            if (expected_tokens.size() > step_base)
                expected_tokens[expected_tokens.size() - 1].last = 1'b1;
        endfunction

        function void report(string what, longint exp_val, longint got_val);
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, what, exp_val, got_val);
        endfunction

        // Compare one output transaction with the oldest expected token
        function void check_token(logic [4:0] kind, logic [23:0] start,
                                  logic [15:0] length, logic last);
            token_t t;
            if (expected_tokens.size() == 0)
            begin
                report("unexpected token, kind", -1, kind);
                return;
            end
            t = expected_tokens.pop_front();
            if (kind != t.kind)
                report("token_kind", t.kind, kind);
            if (start != t.start)
                report("token_start", t.start, start);
            if (length != t.length)
                report("token_length", t.length, length);
            if (last != t.last)
                report("last_token", t.last, last);
        endfunction
    endclass

    logic               clk;
    logic               rst_n;
    logic               s_tvalid;
    logic               s_tready;
    logic [7:0]         s_tdata;
    logic               s_tlast;
    logic [0:0]         s_tuser;
    logic               m_tvalid;
    logic               m_tready;
    logic [TDATA_W-1:0] m_tdata;
    logic [4:0]         m_tuser;
    logic               m_tlast;

    token_scoreboard tok_sb = new();
    int              src_idle_pct;
    int              sink_stall_pct;
    int              bytes_sent;
    int              cycles;
    logic            s_hs;

    source_char_tokenizer u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #1 clk = ~clk;

    // Stall the token side at random
    always @(posedge clk)
    begin
        m_tready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end

    // Sample both handshakes mid-cycle, where every signal has settled
    always @(negedge clk)
    begin
        s_hs = rst_n && s_tvalid && s_tready;
        if (s_hs)
            tok_sb.take_byte(s_tdata, s_tuser[0], s_tlast);
        if (rst_n && m_tvalid && m_tready)
            tok_sb.check_token(m_tuser, m_tdata[23:0], m_tdata[39:24], m_tlast);
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Drive one input transaction and hold it until accepted
    task automatic send_item(input logic [7:0] c, input logic char_valid, input logic eos);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid   <= 1'b1;
        s_tdata    <= c;
        s_tuser[0] <= char_valid;
        s_tlast    <= eos;
        do
            @(posedge clk);
        while (!s_hs);
        if (char_valid)
            bytes_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_item(s[i], 1'b1, 1'b0);
    endtask

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 3) == 0)
            return 8'("A" + $urandom_range(0, 25));
        return 8'("a" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_alnum();
        if ($urandom_range(0, 2) == 0)
            return 8'("0" + $urandom_range(0, 9));
        return rand_letter();
    endfunction

    function automatic logic [7:0] rand_space();
        if ($urandom_range(0, 5) == 0)
            return 8'(9 + $urandom_range(0, 4));
        return " ";
    endfunction

    // Send one lexeme, mostly well formed, sometimes noise or a broken pair
    task automatic random_piece();
        string      kw;
        string      ops;
        logic [7:0] br;
        kw  = token_scoreboard::keyword_text[$urandom_range(0, 5)];
        ops = "+-*/=;";
        br  = $urandom_range(0, 1) ? 8'h3C : 8'h3E;
        case ($urandom_range(0, 13))
            0, 1, 2: send_text(kw);
            3:
            begin
                send_text(kw);
                send_item(rand_alnum(), 1'b1, 1'b0);
            end
            4: send_text(kw.substr(0, kw.len() - 2));
            5, 6:
            begin
                send_item(rand_letter(), 1'b1, 1'b0);
                repeat ($urandom_range(0, 8))
                    send_item(rand_alnum(), 1'b1, 1'b0);
            end
            7:
            begin
                repeat ($urandom_range(1, 5))
                    send_item(8'("0" + $urandom_range(0, 9)), 1'b1, 1'b0);
            end
            8, 9: send_item(ops[$urandom_range(0, 5)], 1'b1, 1'b0);
            10:
            begin
                send_item(br, 1'b1, 1'b0);
                send_item(br, 1'b1, 1'b0);
            end
            11: send_item(br, 1'b1, 1'b0);
            12: send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
            default: send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        endcase
        if ($urandom_range(0, 1))
            send_item(rand_space(), 1'b1, 1'b0);
    endtask

    // One source of random lexemes, closed by end of source
    task automatic random_source(input int min_bytes);
        int first;
        first = bytes_sent;
        while (bytes_sent - first < min_bytes)
            random_piece();
        if ($urandom_range(0, 1))
            send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        else
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    endtask

    // Hold off the sender until every expected token has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        while (tok_sb.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    initial
    begin
        int first;
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tlast        = 1'b0;
        s_tuser        = '0;
        m_tready       = 1'b0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        bytes_sent     = 0;
        cycles         = 0;
        s_hs           = 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: keyword, every operator, pairs, lone brackets, byte extremes
        send_text("int+9<<");
        send_text(">a>>-*/=;");
        send_item(8'hFF, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(" ", 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b0);
        // Pending bracket at end, end-only source, three tokens from one byte
        send_text("x7");
        send_item("<", 1'b1, 1'b1);
        send_item(8'h00, 1'b0, 1'b1);
        send_item("q", 1'b1, 1'b0);
        send_item("+", 1'b1, 1'b1);
        drain();

        // Random sources under three idling patterns
        for (int p = 0; p < 3; p++)
        begin
            src_idle_pct   = (p == 0) ? 22 : (p == 1) ? 73 : 0;
            sink_stall_pct = (p == 0) ? 73 : (p == 1) ? 22 : 0;
            first = bytes_sent;
            while (bytes_sent - first < 22)
                random_source($urandom_range(1, 12));
            drain();
        end
        repeat (16) @(posedge clk);

        if (tok_sb.errors == 0 && tok_sb.pending() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
